@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg: shared constants and types of the stereo soft-knee clipper
// Holds register codes and reset values, the fixed-point widths of the lane
// datapath and the pipeline depth.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Default build of the top level
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LANES_DEF       = 2;

  // Configuration registers
  localparam int LEVEL_BITS    = 23;
  localparam int RATIO_BITS    = 16;
  localparam int CFG_DATA_BITS = LEVEL_BITS;
  localparam int REG_IDX_BITS  = 2;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_CLIP_LEVEL = 2'd0;
  localparam reg_idx_t REG_RATIO      = 2'd1;
  localparam reg_idx_t REG_ENABLE     = 2'd2;

  localparam logic [LEVEL_BITS-1:0] CLIP_LEVEL_RST = 23'd4194304;
  localparam logic [RATIO_BITS-1:0] RATIO_RST      = 16'd16384;
  localparam logic                  ENABLE_RST     = 1'b1;

  // Bypass when level >= 1.99 in Q2.21, i.e. level * 100 >= 199 * 2^21
  localparam logic [LEVEL_BITS-1:0] BYPASS_MIN =
    LEVEL_BITS'((199 * (1 << 21) + 99) / 100);

  // Knee arithmetic: comparisons in units of 2^-16 of a sample LSB
  localparam int FRAC_SHIFT = 16;
  localparam int KNEE_BITS  = LEVEL_BITS + RATIO_BITS;   // half-width h = r*L
  localparam int D_BITS     = KNEE_BITS + 1;             // distance up to 2h
  localparam int HALF_BITS  = (D_BITS + 1) / 2;          // square split point
  localparam int PROD_BITS  = 2 * HALF_BITS;
  localparam int N_BITS     = 2 * D_BITS;                // d^2
  localparam int DIV_SHIFT  = 18;                        // divisor is h << 18
  localparam int REM_BITS   = N_BITS - DIV_SHIFT;
  localparam int Q_BITS     = 24;                        // knee quotient bits

  // Input register, classify, partial products, sum, quotient steps, output
  localparam int LATENCY = Q_BITS + 5;

  // Region of a sample magnitude against the knee
  typedef logic [1:0] cls_t;

  localparam cls_t CLS_ZERO = 2'd0;
  localparam cls_t CLS_PASS = 2'd1;
  localparam cls_t CLS_HARD = 2'd2;
  localparam cls_t CLS_KNEE = 2'd3;

endpackage

@@ rtl/ssc_div_step.sv @@
// ----------------------------------------------------------------------------
// ssc_div_step: one registered step of the knee quotient pipeline
// Decides one quotient bit by a trial subtraction of the shifted knee
// half-width from the partial remainder.
// ----------------------------------------------------------------------------
module ssc_div_step #(
  parameter int BIT_POS = 0
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [ssc_pkg::KNEE_BITS-1:0] knee_k,
  input  logic [ssc_pkg::REM_BITS-1:0]  rem_in,
  input  logic [ssc_pkg::Q_BITS-1:0]    quot_in,
  output logic [ssc_pkg::REM_BITS-1:0]  rem_out,
  output logic [ssc_pkg::Q_BITS-1:0]    quot_out
);
  import ssc_pkg::*;

  logic [REM_BITS-1:0] trial;
  logic                take;
  logic [REM_BITS-1:0] rem_next;
  logic [Q_BITS-1:0]   quot_next;

  // Trial subtract of h << BIT_POS
  always_comb begin
    trial     = REM_BITS'(knee_k) << BIT_POS;
    take      = (rem_in >= trial);
    rem_next  = take ? (rem_in - trial) : rem_in;
    quot_next = take ? (quot_in | (Q_BITS'(1) << BIT_POS)) : quot_in;
  end

  // Advance with the lane
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= rem_next;
      quot_out <= quot_next;
    end
  end

endmodule

@@ rtl/ssc_lane.sv @@
// ----------------------------------------------------------------------------
// ssc_lane: soft-knee clip pipeline for one channel
// Takes the magnitude, classifies it against the knee, squares the knee
// distance in partial products, divides by the knee half-width one bit a stage
// and restores the sign.
// ----------------------------------------------------------------------------
module ssc_lane #(
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [ssc_pkg::LEVEL_BITS-1:0] level,
  input  logic [ssc_pkg::KNEE_BITS-1:0]  knee_k,
  input  logic                          bypass,
  output logic [SAMPLE_BITS-1:0]        result
);
  import ssc_pkg::*;

  localparam int A_W        = SAMPLE_BITS + FRAC_SHIFT;
  localparam int CMP_W      = ((A_W > KNEE_BITS + 1) ? A_W : KNEE_BITS + 1) + 1;
  localparam int MAG_W      = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
  localparam int SIDE_DEPTH = Q_BITS + 3;

  typedef struct packed {
    cls_t                   cls;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag_in;
    logic [SAMPLE_BITS-1:0] raw;
  } side_t;

  // Stage 1: input sample and magnitude
  logic [SAMPLE_BITS-1:0] raw_q;
  logic [SAMPLE_BITS-1:0] abs_q;
  logic                   neg_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_q <= sample;
      neg_q <= sample[SAMPLE_BITS-1];
      abs_q <= sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    end
  end

  // Stage 2: classify against the knee, distance from its top
  logic [CMP_W-1:0]  a_ext;
  logic [CMP_W-1:0]  ls_ext;
  logic [CMP_W-1:0]  k_ext;
  logic [CMP_W-1:0]  diff;
  logic              below;
  logic              above;
  cls_t              cls_next;
  side_t             side [SIDE_DEPTH];
  logic [D_BITS-1:0] d_q;

  always_comb begin
    a_ext  = CMP_W'(abs_q) << FRAC_SHIFT;
    ls_ext = CMP_W'(level) << FRAC_SHIFT;
    k_ext  = CMP_W'(knee_k);
    below  = (a_ext + k_ext) < ls_ext;
    above  = a_ext > (ls_ext + k_ext);
    diff   = ls_ext + k_ext - a_ext;
    if (level == '0) begin
      cls_next = CLS_ZERO;
    end else if (below) begin
      cls_next = CLS_PASS;
    end else if (above || (knee_k == '0)) begin
      cls_next = CLS_HARD;
    end else begin
      cls_next = CLS_KNEE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{cls: cls_next, neg: neg_q, mag_in: abs_q, raw: raw_q};
      d_q     <= diff[D_BITS-1:0];
    end
  end

  // Stage 3: partial products of the square
  logic [D_BITS-HALF_BITS-1:0] d_hi;
  logic [HALF_BITS-1:0]        d_lo;
  logic [PROD_BITS-1:0]        p_hh;
  logic [PROD_BITS-1:0]        p_hl;
  logic [PROD_BITS-1:0]        p_ll;

  assign d_hi = d_q[D_BITS-1:HALF_BITS];
  assign d_lo = d_q[HALF_BITS-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_hh <= PROD_BITS'(d_hi) * PROD_BITS'(d_hi);
      p_hl <= PROD_BITS'(d_hi) * PROD_BITS'(d_lo);
      p_ll <= PROD_BITS'(d_lo) * PROD_BITS'(d_lo);
    end
  end

  // Stage 4: sum the square, split off the low bits of the divisor shift
  logic [N_BITS-1:0]   n_sum;
  logic [REM_BITS-1:0] rem_c  [Q_BITS+1];
  logic [Q_BITS-1:0]   quot_c [Q_BITS+1];
  logic                sticky [Q_BITS+1];

  assign n_sum = (N_BITS'(p_hh) << (2 * HALF_BITS))
               + (N_BITS'(p_hl) << (HALF_BITS + 1))
               + N_BITS'(p_ll);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_c[0]  <= n_sum[N_BITS-1:DIV_SHIFT];
      sticky[0] <= |n_sum[DIV_SHIFT-1:0];
    end
  end

  assign quot_c[0] = '0;

  // Quotient steps, most significant bit first
  for (genvar j = 0; j < Q_BITS; j++) begin : g_step
    ssc_div_step #(
      .BIT_POS (Q_BITS - 1 - j)
    ) u_step (
      .clk      (clk),
      .adv      (adv),
      .knee_k   (knee_k),
      .rem_in   (rem_c[j]),
      .quot_in  (quot_c[j]),
      .rem_out  (rem_c[j+1]),
      .quot_out (quot_c[j+1])
    );
  end

  // Carry the side data and the sticky bit along the steps
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side[k] <= side[k-1];
      end
      for (int k = 1; k <= Q_BITS; k++) begin
        sticky[k] <= sticky[k-1];
      end
    end
  end

  // Output stage: round the quotient up, pick the magnitude, restore sign, or pass the raw sample in bypass
  side_t                 side_f;
  logic                  round_up;
  logic [Q_BITS:0]       q_full;
  logic [Q_BITS:0]       level_ext;
  logic [Q_BITS:0]       knee_diff;
  logic [LEVEL_BITS-1:0] knee_mag;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      signed_mag;
  logic [SAMPLE_BITS-1:0] result_next;

  always_comb begin
    side_f    = side[SIDE_DEPTH-1];
    round_up  = (rem_c[Q_BITS] != '0) || sticky[Q_BITS];
    q_full    = {1'b0, quot_c[Q_BITS]} + (Q_BITS + 1)'(round_up);
    level_ext = (Q_BITS + 1)'(level);
    knee_diff = level_ext - q_full;
    knee_mag  = (q_full >= level_ext) ? '0 : knee_diff[LEVEL_BITS-1:0];
    case (side_f.cls)
      CLS_ZERO: mag = '0;
      CLS_PASS: mag = MAG_W'(side_f.mag_in);
      CLS_HARD: mag = MAG_W'(level);
      default:  mag = MAG_W'(knee_mag);
    endcase
    signed_mag  = side_f.neg ? (~mag + MAG_W'(1)) : mag;
    result_next = bypass ? side_f.raw : signed_mag[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/ssc_merge.sv @@
// ----------------------------------------------------------------------------
// ssc_merge: lane merge and output skid buffer
// Packs the lane results into one output request and parts the lane
// pipeline from the output handshake with an output register and a skid.
// ----------------------------------------------------------------------------
module ssc_merge #(
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int LANES       = ssc_pkg::LANES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [SAMPLE_BITS-1:0]                   lane_res [LANES],
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata
);
  import ssc_pkg::*;

  localparam int DATA_W = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

  logic [DATA_W-1:0] packed_res;
  logic [DATA_W-1:0] skid_data;
  logic              skid_full;
  logic              accept_in;
  logic              out_free;

  // Pack lanes, lane 0 in the lowest bits, zero fill to whole bytes
  always_comb begin
    packed_res = '0;
    for (int i = 0; i < LANES; i++) begin
      packed_res[i*SAMPLE_BITS +: SAMPLE_BITS] = lane_res[i];
    end
  end

  assign in_ready  = !skid_full;
  assign accept_in = in_valid && in_ready;
  assign out_free  = !m_tvalid || m_tready;

  // Output and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        m_tvalid  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        m_tvalid <= accept_in;
      end
    end else if (accept_in) begin
      skid_full <= 1'b1;
    end
  end

  // Output and skid data
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_full) begin
        m_tdata <= skid_data;
      end else if (accept_in) begin
        m_tdata <= packed_res;
      end
    end else if (accept_in) begin
      skid_data <= packed_res;
    end
  end

  // The skid only fills behind a held output request
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid)
    else $error("skid holds data while the output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without an output stall");

endmodule

@@ rtl/stereo_soft_knee_clipper.sv @@
// ----------------------------------------------------------------------------
// stereo_soft_knee_clipper: soft-knee clipper for a stereo sample pair
// One pipelined lane per channel clips each sample to the level with a
// quadratic knee of half-width ratio*level; a merge stage packs the results.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid/s_tready    s_tdata: one sample per lane
//   m_*      out        m_tvalid/m_tready    m_tdata: one result per lane
//   cfg_*    in         cfg_write            cfg_index, cfg_data
//
// Takes one sample pair per cycle unless the output stalls; each pair passes
// the 24-step quotient pipeline of the knee term on its way to the merge.
// Reset loads level 2.0, ratio 0.25, enable on, and empties the pipeline.
// A held output request with a full skid freezes all lanes; s_tready then
// drops until the output moves.
// ----------------------------------------------------------------------------
module stereo_soft_knee_clipper #(
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int LANES       = ssc_pkg::LANES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Sample pair in: lane i sample at [i*SAMPLE_BITS +: SAMPLE_BITS]
  // (left_sample, right_sample from the lowest bit up)
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // Result pair out: (left_out, right_out from the lowest bit up)
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // Register write port
  input  logic                                   cfg_write,
  input  ssc_pkg::reg_idx_t                      cfg_index,
  input  logic [ssc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import ssc_pkg::*;

  // Configuration registers
  logic [LEVEL_BITS-1:0] clip_level;
  logic [RATIO_BITS-1:0] ratio;
  logic                  enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_level <= CLIP_LEVEL_RST;
      ratio      <= RATIO_RST;
      enable     <= ENABLE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLIP_LEVEL: clip_level <= cfg_data;
        REG_RATIO:      ratio      <= cfg_data[RATIO_BITS-1:0];
        REG_ENABLE:     enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Derived settings: knee half-width and bypass
  logic [KNEE_BITS-1:0] knee_k;
  logic                 bypass;

  always_ff @(posedge clk) begin
    knee_k <= KNEE_BITS'(ratio) * KNEE_BITS'(clip_level);
    bypass <= !enable || (clip_level >= BYPASS_MIN);
  end

  // Pipeline valid chain, advancing when the merge stage can take
  logic               adv;
  logic [LATENCY-1:0] vld;

  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end

  // Lanes
  logic [SAMPLE_BITS-1:0] lane_res [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ssc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .sample (s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .level  (clip_level),
      .knee_k (knee_k),
      .bypass (bypass),
      .result (lane_res[i])
    );
  end

  // Merge and output
  ssc_merge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LANES       (LANES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[LATENCY-1]),
    .in_ready (adv),
    .lane_res (lane_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A finished pair always reaches the output
  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    (vld[LATENCY-1] && adv) |=> m_tvalid)
    else $error("finished pair did not reach the output");

  // The pipeline stalls only behind a held output request
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !adv |-> m_tvalid)
    else $error("pipeline stalled with an empty output");

endmodule
